>>> design/mcpg_pkg.sv
package mcpg_pkg;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    typedef logic [2:0] t_octant;

    localparam t_octant OCT_LAST = 3'd7;

    typedef struct packed {
        logic push;
        logic full;
    } t_wr_ctl;

    typedef struct packed {
        logic pop;
        logic empty;
    } t_rd_ctl;

endpackage

>>> design/mcpg_front.sv
module mcpg_front
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int DESC_W     = 4 * COORD_BITS - 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic        [COORD_BITS-2:0] i_radius,
    input  t_wr_ctl                      i_wr_stat,
    output t_wr_ctl                      o_wr_ctl,
    output logic        [DESC_W-1:0]     o_desc
);

    localparam int OB = COORD_BITS - 1;
    localparam int DB = COORD_BITS + 4;

    logic signed [COORD_BITS-1:0] r_cx, r_cy, n_cx, n_cy;
    logic        [OB-1:0]         r_x, r_y, n_x, n_y;
    logic signed [DB-1:0]         r_d, n_d;
    logic                         r_active, n_active;

    logic                         w_take;
    logic                         w_done;
    logic        [OB-1:0]         w_nx, w_ny;
    logic signed [DB-1:0]         w_nx_s, w_ny_s;

    assign o_ready = !i_wr_stat.full;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_x      = r_x;
        n_y      = r_y;
        n_d      = r_d;
        w_nx     = r_x + OB'(1);
        w_ny     = r_y - OB'(1);
        w_nx_s   = $signed({{(DB-OB){1'b0}}, w_nx});
        w_ny_s   = $signed({{(DB-OB){1'b0}}, w_ny});
        if (t_cmd'(i_cmd) == CMD_START) begin
            n_cx = i_center_x;
            n_cy = i_center_y;
            n_x  = '0;
            n_y  = i_radius;
            n_d  = DB'(1) - $signed({{(DB-OB){1'b0}}, i_radius});
        end else if (r_d < 0) begin
            n_x = w_nx;
            n_d = r_d + (w_nx_s <<< 1) + DB'(1);
        end else begin
            n_x = w_nx;
            n_y = w_ny;
            n_d = r_d + ((w_nx_s - w_ny_s) <<< 1) + DB'(1);
        end
        w_done   = n_x >= n_y;
        n_active = !w_done;
    end

    assign o_wr_ctl.push = w_take && (t_cmd'(i_cmd) == CMD_START || r_active);
    assign o_wr_ctl.full = i_wr_stat.full;
    assign o_desc        = {w_done, n_y, n_x, n_cy, n_cx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_active <= 1'b0;
        end else if (o_wr_ctl.push) begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
            r_active <= n_active;
        end
    end

endmodule

>>> design/mcpg_queue.sv
module mcpg_queue
    import mcpg_pkg::*;
#(
    parameter int WIDTH = 47,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_wr_ctl          i_wr_ctl,
    output t_wr_ctl          o_wr_stat,
    input  logic [WIDTH-1:0] i_data,
    input  t_rd_ctl          i_rd_ctl,
    output t_rd_ctl          o_rd_stat,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_wr_stat.push  = 1'b0;
    assign o_wr_stat.full  = r_count == CW'(DEPTH);
    assign o_rd_stat.pop   = 1'b0;
    assign o_rd_stat.empty = r_count == '0;
    assign o_data          = r_mem[r_rptr];

    assign w_push = i_wr_ctl.push && !o_wr_stat.full;
    assign w_pop  = i_rd_ctl.pop && !o_rd_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> design/mcpg_back.sv
module mcpg_back
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int DESC_W     = 4 * COORD_BITS - 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_rd_ctl                    i_rd_stat,
    output t_rd_ctl                    o_rd_ctl,
    input  logic [DESC_W-1:0]          i_desc,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [COORD_BITS:0] o_point_x,
    output logic signed [COORD_BITS:0] o_point_y,
    output logic                       o_last_of_step,
    output logic                       o_circle_done
);

    localparam int OB = COORD_BITS - 1;
    localparam int PB = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] w_cx, w_cy;
    logic        [OB-1:0]         w_a, w_b;
    logic                         w_done;
    logic signed [PB-1:0]         w_ea, w_eb, w_opx, w_opy, w_px, w_py;
    logic                         w_negx, w_negy, w_load;

    t_octant                      r_idx;
    logic                         r_valid;
    logic signed [PB-1:0]         r_px, r_py;
    logic                         r_last, r_done;

    assign {w_done, w_b, w_a, w_cy, w_cx} = i_desc;
    assign w_ea = $signed({{(PB-OB){1'b0}}, w_a});
    assign w_eb = $signed({{(PB-OB){1'b0}}, w_b});

    always_comb begin
        w_opx  = w_ea;
        w_opy  = w_eb;
        w_negx = 1'b0;
        w_negy = 1'b0;
        case (r_idx)
            3'd0: begin w_opx = w_ea; w_negx = 1'b0; w_opy = w_eb; w_negy = 1'b0; end
            3'd1: begin w_opx = w_ea; w_negx = 1'b0; w_opy = w_eb; w_negy = 1'b1; end
            3'd2: begin w_opx = w_eb; w_negx = 1'b0; w_opy = w_ea; w_negy = 1'b0; end
            3'd3: begin w_opx = w_eb; w_negx = 1'b0; w_opy = w_ea; w_negy = 1'b1; end
            3'd4: begin w_opx = w_ea; w_negx = 1'b1; w_opy = w_eb; w_negy = 1'b1; end
            3'd5: begin w_opx = w_eb; w_negx = 1'b1; w_opy = w_ea; w_negy = 1'b1; end
            3'd6: begin w_opx = w_ea; w_negx = 1'b1; w_opy = w_eb; w_negy = 1'b0; end
            default: begin w_opx = w_eb; w_negx = 1'b1; w_opy = w_ea; w_negy = 1'b0; end
        endcase
        w_px = w_negx ? (PB'(w_cx) - w_opx) : (PB'(w_cx) + w_opx);
        w_py = w_negy ? (PB'(w_cy) - w_opy) : (PB'(w_cy) + w_opy);
    end

    assign w_load         = !i_rd_stat.empty && (!r_valid || i_ready);
    assign o_rd_ctl.pop   = w_load && (r_idx == OCT_LAST);
    assign o_rd_ctl.empty = i_rd_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx   <= r_idx + 3'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_px   <= w_px;
            r_py   <= w_py;
            r_last <= r_idx == OCT_LAST;
            r_done <= w_done;
        end
    end

    assign o_valid        = r_valid;
    assign o_point_x      = r_px;
    assign o_point_y      = r_py;
    assign o_last_of_step = r_last;
    assign o_circle_done  = r_done;

endmodule

>>> design/midpoint_circle_point_generator_top.sv
// Channel  Handshake          Payload
// input    i_valid / o_ready  i_cmd, i_center_x, i_center_y, i_radius
// output   o_valid / i_ready  o_point_x, o_point_y, o_last_of_step, o_circle_done
//
// A start, or a step while a circle is in progress, is taken and queued as one run of eight points.
// The output register emits one point per cycle while i_ready is high and the queue holds a run;
// the two-run queue sets how far input runs ahead.
// Reset clears the circle state, the queue and the output valid.
// A stalled output holds its point; input stalls only when the queue is full.
module midpoint_circle_point_generator_top
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic        [COORD_BITS-2:0] i_radius,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS:0]   o_point_x,
    output logic signed [COORD_BITS:0]   o_point_y,
    output logic                         o_last_of_step,
    output logic                         o_circle_done
);

    localparam int DESC_W = 4 * COORD_BITS - 1;

    t_wr_ctl           w_wr_ctl, w_wr_stat;
    t_rd_ctl           w_rd_ctl, w_rd_stat;
    logic [DESC_W-1:0] w_desc_in, w_desc_out;

    mcpg_front #(
        .COORD_BITS(COORD_BITS),
        .DESC_W    (DESC_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .i_center_x(i_center_x),
        .i_center_y(i_center_y),
        .i_radius  (i_radius),
        .i_wr_stat (w_wr_stat),
        .o_wr_ctl  (w_wr_ctl),
        .o_desc    (w_desc_in)
    );

    mcpg_queue #(
        .WIDTH(DESC_W),
        .DEPTH(2)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_ctl (w_wr_ctl),
        .o_wr_stat(w_wr_stat),
        .i_data   (w_desc_in),
        .i_rd_ctl (w_rd_ctl),
        .o_rd_stat(w_rd_stat),
        .o_data   (w_desc_out)
    );

    mcpg_back #(
        .COORD_BITS(COORD_BITS),
        .DESC_W    (DESC_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_stat     (w_rd_stat),
        .o_rd_ctl      (w_rd_ctl),
        .i_desc        (w_desc_out),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_last_of_step(o_last_of_step),
        .o_circle_done (o_circle_done)
    );

endmodule

>>> design/mcpg_checker.sv
module mcpg_checker
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic signed [COORD_BITS:0] o_point_x,
    input logic signed [COORD_BITS:0] o_point_y,
    input logic                       o_last_of_step,
    input logic                       o_circle_done
);

    t_octant r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_valid && i_ready) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    a_reset_clears_valid: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_last_every_eighth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_step == (r_cnt == OCT_LAST)))
        else $error("last_of_step out of place in run");

    a_done_steady_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_step |=>
            !o_valid || (o_circle_done == $past(o_circle_done)))
        else $error("circle_done changed within a run");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_point_x) && $stable(o_point_y))
        else $error("stalled point changed");

endmodule

bind midpoint_circle_point_generator_top mcpg_checker #(
    .COORD_BITS(COORD_BITS)
) u_mcpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_point_x     (o_point_x),
    .o_point_y     (o_point_y),
    .o_last_of_step(o_last_of_step),
    .o_circle_done (o_circle_done)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mcpg_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_RUNS  = 72;

    typedef struct {
        logic signed [COORD_BITS:0] px;
        logic signed [COORD_BITS:0] py;
        logic                       last;
        logic                       done;
    } t_point;

    class circle_tracker;
        logic signed [COORD_BITS-1:0] ctr_x;
        logic signed [COORD_BITS-1:0] ctr_y;
        int     off_x;
        int     off_y;
        int     dec;
        bit     drawing;
        t_point pending_points[$];
        int     errors;
        int     points_seen;
        int     runs;
        int     circles_done;

        function new();
            ctr_x        = '0;
            ctr_y        = '0;
            off_x        = 0;
            off_y        = 0;
            dec          = 0;
            drawing      = 1'b0;
            errors       = 0;
            points_seen  = 0;
            runs         = 0;
            circles_done = 0;
        endfunction

        function int pending();
            return pending_points.size();
        endfunction

        function void take_command(input t_cmd cmd,
                                   input logic signed [COORD_BITS-1:0] cx,
                                   input logic signed [COORD_BITS-1:0] cy,
                                   input logic [COORD_BITS-2:0] r);
            int     sx[8];
            int     sy[8];
            bit     fin;
            t_point p;
            if (cmd == CMD_START) begin
                ctr_x = cx;
                ctr_y = cy;
                off_x = 0;
                off_y = int'(r);
                dec   = 1 - int'(r);
            end else begin
                if (!drawing) return;
                off_x = off_x + 1;
                if (dec < 0) begin
                    dec = dec + 2 * off_x + 1;
                end else begin
                    off_y = off_y - 1;
                    dec   = dec + 2 * (off_x - off_y) + 1;
                end
            end
            fin     = (off_x >= off_y);
            drawing = !fin;
            sx = '{off_x, off_x, off_y, off_y, -off_x, -off_y, -off_x, -off_y};
            sy = '{off_y, -off_y, off_x, -off_x, -off_y, -off_x, off_y, off_x};
            for (int k = 0; k < 8; k++) begin
                p.px   = (COORD_BITS + 1)'(int'(ctr_x) + sx[k]);
                p.py   = (COORD_BITS + 1)'(int'(ctr_y) + sy[k]);
                p.last = (k == 7);
                p.done = fin;
                pending_points.push_back(p);
            end
            runs++;
            if (fin) circles_done++;
        endfunction

        function void check_point(input logic signed [COORD_BITS:0] px,
                                  input logic signed [COORD_BITS:0] py,
                                  input logic last,
                                  input logic done);
            t_point e;
            points_seen++;
            if (pending_points.size() == 0) begin
                $error("unexpected point x=%0d y=%0d last=%0b done=%0b", px, py, last, done);
                errors++;
                return;
            end
            e = pending_points.pop_front();
            if (px !== e.px) begin
                $error("point_x: expected %0d, actual %0d", e.px, px);
                errors++;
            end
            if (py !== e.py) begin
                $error("point_y: expected %0d, actual %0d", e.py, py);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_of_step: expected %0b, actual %0b", e.last, last);
                errors++;
            end
            if (done !== e.done) begin
                $error("circle_done: expected %0b, actual %0b", e.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_valid    = 1'b0;
    logic                         o_ready;
    logic                         i_cmd      = 1'b0;
    logic signed [COORD_BITS-1:0] i_center_x = '0;
    logic signed [COORD_BITS-1:0] i_center_y = '0;
    logic        [COORD_BITS-2:0] i_radius   = '0;
    logic                         o_valid;
    logic                         i_ready    = 1'b0;
    logic signed [COORD_BITS:0]   o_point_x;
    logic signed [COORD_BITS:0]   o_point_y;
    logic                         o_last_of_step;
    logic                         o_circle_done;

    logic                         in_fire_s  = 1'b0;
    logic                         out_fire_s = 1'b0;
    logic signed [COORD_BITS:0]   px_s;
    logic signed [COORD_BITS:0]   py_s;
    logic                         last_s;
    logic                         done_s;

    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    int cycle_count   = 0;

    circle_tracker track = new();

    midpoint_circle_point_generator_top #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    always #4 i_clk = ~i_clk;

    // sample handshakes mid-cycle, consume them at the next rising edge
    always @(negedge i_clk) begin
        in_fire_s  <= i_rst_n && i_valid && o_ready;
        out_fire_s <= i_rst_n && o_valid && i_ready;
        px_s       <= o_point_x;
        py_s       <= o_point_y;
        last_s     <= o_last_of_step;
        done_s     <= o_circle_done;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= dst_stall_pct);
        if (out_fire_s) track.check_point(px_s, py_s, last_s, done_s);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_item(input t_cmd cmd,
                             input logic signed [COORD_BITS-1:0] cx,
                             input logic signed [COORD_BITS-1:0] cy,
                             input logic [COORD_BITS-2:0] r);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= r;
        @(posedge i_clk);
        while (!in_fire_s) @(posedge i_clk);
        track.take_command(cmd, cx, cy, r);
    endtask

    task automatic send_noise_step();
        send_item(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  (COORD_BITS - 1)'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (track.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_circle();
        int pick;
        int r;
        int max_steps;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 80) r = $urandom_range(0, 24);
        else if (pick < 95) r = $urandom_range(25, 60);
        else r = $urandom_range(61, 2047);
        if (r > 60) max_steps = $urandom_range(1, 6);
        else if ($urandom_range(0, 99) < 15) max_steps = $urandom_range(0, r);
        else max_steps = 4096;
        send_item(CMD_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  (COORD_BITS - 1)'(r));
        n = 0;
        while (track.drawing && n < max_steps) begin
            send_noise_step();
            n++;
        end
        if (!track.drawing && $urandom_range(0, 3) == 0) send_noise_step();
    endtask

    task automatic run_phase(input int src_pct, input int dst_pct);
        int target;
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
        target = track.runs + PHASE_RUNS;
        while (track.runs < target) begin
            if ($urandom_range(0, 99) < 90) random_circle();
            else send_noise_step();
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // step with no circle, zero radius, step after done
        send_item(CMD_STEP, 12'sd5, -12'sd5, 11'd3);
        send_item(CMD_START, 12'sd0, 12'sd0, 11'd0);
        send_item(CMD_STEP, 12'sd0, 12'sd0, 11'd0);
        send_item(CMD_START, 12'sd2047, -12'sd2048, 11'd1);
        send_item(CMD_STEP, -12'sd1, 12'sd1, 11'd2047);
        send_item(CMD_STEP, 12'sd0, 12'sd0, 11'd0);
        // full radius at extreme corners, then abort with a new start
        send_item(CMD_START, -12'sd2048, 12'sd2047, 11'd2047);
        send_item(CMD_STEP, 12'sd0, 12'sd0, 11'd0);
        send_item(CMD_STEP, 12'sd0, 12'sd0, 11'd0);
        send_item(CMD_STEP, 12'sd0, 12'sd0, 11'd0);
        send_item(CMD_START, 12'sd2047, 12'sd2047, 11'd5);
        while (track.drawing) send_item(CMD_STEP, -12'sd2048, -12'sd2048, 11'd2047);
        send_item(CMD_STEP, 12'sd0, 12'sd0, 11'd0);
        send_item(CMD_START, 12'sd2047, -12'sd2048, 11'd2047);
        send_item(CMD_STEP, 12'sd0, 12'sd0, 11'd0);
        send_item(CMD_STEP, 12'sd0, 12'sd0, 11'd0);
        send_item(CMD_START, -12'sd2048, -12'sd2048, 11'd2047);
        send_item(CMD_STEP, 12'sd0, 12'sd0, 11'd0);
        send_item(CMD_START, 12'sd100, -12'sd100, 11'd1024);
        drain();

        run_phase(0, 0);
        run_phase(69, 0);
        run_phase(0, 69);
        run_phase(20, 20);

        repeat (24) @(posedge i_clk);
        if (track.pending() != 0) begin
            $error("%0d expected points never arrived", track.pending());
            track.errors++;
        end
        $display("Covered %0d runs of eight points (%0d checked), %0d circles drawn to the end,",
                 track.runs, track.points_seen, track.circles_done);
        $display("with aborts, idle steps and four sender/receiver idling mixes.");
        if (track.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
